>>> src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/mvsm_pkg.sv
// Shared constants and types for the multi-voice sample mixer
`default_nettype none
package mvsm_pkg;
  localparam int Voices = 16;
  localparam int VoiceBits = 4;
  localparam int MemAddrBits = 16;
  localparam int MemWords = 1 << MemAddrBits;

  localparam logic [2:0] ModeWrite = 3'd0;
  localparam logic [2:0] ModeStart = 3'd1;
  localparam logic [2:0] ModePause = 3'd2;
  localparam logic [2:0] ModeStop  = 3'd3;
  localparam logic [2:0] ModeTick  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [15:0] sample_value;
    logic [15:0] voice_length;
    logic [15:0] gain_ch0;
    logic [15:0] gain_ch1;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic           load;      // capture input item, run the modes that need no voice sweep
    logic           acc_clr;   // clear accumulators
    logic           rd_issue;  // issue memory read for current voice/channel
    logic           mac;       // accumulate the previous read
    logic [VoiceBits-1:0] rd_voice;
    logic           rd_ch;
    logic [VoiceBits-1:0] mac_voice;
    logic           mac_ch;
    logic           finish;    // advance voices, form the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick_play;
  } sts_t;
endpackage
`default_nettype wire

>>> src/multi_voice_sample_mixer_core.sv
// Multi-voice sample mixer: one result per item.
// Every result is registered; a playing tick forms its result only after a sweep over the voices.
// Throughput: one non-tick item per cycle when the output is taken; a playing tick
// holds the block for the voice sweep of one multiply-accumulate per voice channel.
// Reset clears voices and the play flag; sample memory is undefined until written.
`default_nettype none
module multi_voice_sample_mixer_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0]
  input  wire  [2:0]  s_axis_tuser,
  // address[15:0] sample_value[31:16] voice_length[47:32]
  // gain_ch0[63:48] gain_ch1[79:64]
  input  wire  [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // out_ch0[15:0] out_ch1[31:16] slot[35:32] slots_full[36] any_active[37], zero in [39:38]
  output logic [39:0] m_axis_tdata
);
  import mvsm_pkg::*;

  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  logic [15:0] o0, o1;
  logic [3:0]  slot;
  logic        full, act;

  assign item.mode = s_axis_tuser;
  assign item.address = s_axis_tdata[15:0];
  assign item.sample_value = s_axis_tdata[31:16];
  assign item.voice_length = s_axis_tdata[47:32];
  assign item.gain_ch0 = s_axis_tdata[63:48];
  assign item.gain_ch1 = s_axis_tdata[79:64];

  mvsm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  mvsm_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .cmd_i(cmd), .sts_o(sts),
    .out_ch0_o(o0), .out_ch1_o(o1), .slot_o(slot), .slots_full_o(full), .any_active_o(act)
  );

  assign m_axis_tdata = {2'b00, act, full, slot, o1, o0};
endmodule
`default_nettype wire

>>> src/mvsm_datapath.sv
// Voice table, sample memory, shared multiply-accumulate and result register
`default_nettype none
module mvsm_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mvsm_pkg::item_t     item_i,
  input  mvsm_pkg::cmd_t      cmd_i,
  output mvsm_pkg::sts_t      sts_o,
  output logic [15:0]         out_ch0_o,
  output logic [15:0]         out_ch1_o,
  output logic [3:0]          slot_o,
  output logic                slots_full_o,
  output logic                any_active_o
);
  import mvsm_pkg::*;

  logic [15:0] mem [MemWords];
  logic [15:0] rd_q;

  logic [Voices-1:0] act_q, act_d;
  logic [15:0] base_q [Voices];
  logic [15:0] frames_q [Voices];
  logic [15:0] pos_q [Voices];
  logic [15:0] g0_q [Voices];
  logic [15:0] g1_q [Voices];
  logic        playing_q;
  logic        tick_act_q;
  logic [VoiceBits-1:0] free_idx;
  logic        free_found;
  logic signed [40:0] acc0_q, acc1_q;
  logic signed [16:0] gain_s;
  logic signed [33:0] prod;
  logic        in_range_q;
  logic [MemAddrBits-1:0] rd_addr;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int v = Voices - 1; v >= 0; v--) begin
      if (!act_q[v]) begin
        free_found = 1'b1;
        free_idx = VoiceBits'(v);
      end
    end
  end

  assign sts_o.is_tick_play = (item_i.mode == ModeTick) && playing_q;

  assign rd_addr = MemAddrBits'(base_q[cmd_i.rd_voice] + {pos_q[cmd_i.rd_voice][14:0], 1'b0}
                   + {15'd0, cmd_i.rd_ch});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && item_i.mode == ModeWrite) begin
      mem[item_i.address[MemAddrBits-1:0]] <= item_i.sample_value;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      in_range_q <= act_q[cmd_i.rd_voice] && (pos_q[cmd_i.rd_voice] < frames_q[cmd_i.rd_voice]);
    end
  end

  assign gain_s = cmd_i.mac_ch ? {1'b0, g1_q[cmd_i.mac_voice]} : {1'b0, g0_q[cmd_i.mac_voice]};
  assign prod = $signed(rd_q) * gain_s;

  always_comb begin
    act_d = act_q;
    for (int v = 0; v < Voices; v++) begin
      if (act_q[v] && (pos_q[v] + 16'd1 >= frames_q[v])) act_d[v] = 1'b0;
    end
  end

  function automatic logic [15:0] scale_sat(input logic signed [40:0] a);
    logic signed [25:0] q;
    q = a[40:15];
    if (q > 26'sd32767) return 16'h7fff;
    if (q < -26'sd32768) return 16'h8000;
    return q[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (cmd_i.mac && in_range_q) begin
      if (cmd_i.mac_ch) acc1_q <= acc1_q + 41'(prod);
      else acc0_q <= acc0_q + 41'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      playing_q <= 1'b0;
      tick_act_q <= 1'b0;
      out_ch0_o <= '0;
      out_ch1_o <= '0;
      slot_o <= '0;
      slots_full_o <= 1'b0;
      any_active_o <= 1'b0;
      for (int v = 0; v < Voices; v++) begin
        base_q[v] <= '0; frames_q[v] <= '0; pos_q[v] <= '0; g0_q[v] <= '0; g1_q[v] <= '0;
      end
    end else if (cmd_i.load) begin
      out_ch0_o <= '0;
      out_ch1_o <= '0;
      slot_o <= '0;
      slots_full_o <= 1'b0;
      tick_act_q <= |act_q;
      case (item_i.mode)
        ModeStart: begin
          playing_q <= 1'b1;
          if (free_found) begin
            act_q[free_idx] <= 1'b1;
            base_q[free_idx] <= item_i.address;
            frames_q[free_idx] <= item_i.voice_length;
            pos_q[free_idx] <= '0;
            g0_q[free_idx] <= item_i.gain_ch0;
            g1_q[free_idx] <= item_i.gain_ch1;
            slot_o <= 4'(free_idx);
            any_active_o <= 1'b1;
          end else begin
            slots_full_o <= 1'b1;
            any_active_o <= |act_q;
          end
        end
        ModePause: begin
          playing_q <= 1'b0;
          any_active_o <= |act_q;
        end
        ModeStop: begin
          playing_q <= 1'b0;
          act_q <= '0;
          any_active_o <= 1'b0;
        end
        default: any_active_o <= |act_q;
      endcase
    end else if (cmd_i.finish) begin
      out_ch0_o <= scale_sat(acc0_q);
      out_ch1_o <= scale_sat(acc1_q);
      any_active_o <= tick_act_q;
      act_q <= act_d;
      for (int v = 0; v < Voices; v++) begin
        if (act_q[v]) pos_q[v] <= pos_q[v] + 16'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/mvsm_ctrl.sv
// Sequencer for the handshake and the per-voice multiply-accumulate sweep
`default_nettype none
module mvsm_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  mvsm_pkg::sts_t  sts_i,
  output mvsm_pkg::cmd_t  cmd_o
);
  import mvsm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StLast = 2'd2;

  logic [1:0] state_q, state_d;
  logic [VoiceBits:0] idx_q, idx_d;
  logic valid_q, valid_d;
  logic mac_q;
  logic [VoiceBits:0] mac_idx_q;
  logic accept;

  assign in_ready_o = (state_q == StIdle) && (!valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    valid_d = valid_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.rd_voice = idx_q[VoiceBits:1];
    cmd_o.rd_ch = idx_q[0];
    cmd_o.mac_voice = mac_idx_q[VoiceBits:1];
    cmd_o.mac_ch = mac_idx_q[0];
    cmd_o.mac = mac_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (sts_i.is_tick_play) begin
            cmd_o.acc_clr = 1'b1;
            idx_d = '0;
            state_d = StRun;
          end else begin
            valid_d = 1'b1;
          end
        end
      end
      StRun: begin
        cmd_o.rd_issue = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == (VoiceBits+1)'(2 * Voices - 1)) state_d = StLast;
      end
      StLast: begin
        if (!mac_q) begin
          cmd_o.finish = 1'b1;
          valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      valid_q <= 1'b0;
      mac_q <= 1'b0;
      mac_idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      valid_q <= valid_d;
      mac_q <= cmd_o.rd_issue;
      mac_idx_q <= idx_q;
    end
  end
endmodule
`default_nettype wire

>>> src/mvsm_checker.sv
// Port-level checker for the mixer, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mvsm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [2:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);
  import mvsm_pkg::*;

  wire out_full = m_axis_tvalid && m_axis_tdata[36];
  wire out_stall = m_axis_tvalid && !m_axis_tready;
  wire stop_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeStop);

  `ASSERT_IMPL(full_no_slot, clk_i, rst_ni, out_full, m_axis_tdata[35:32] == 4'd0)
  `ASSERT_IMPL(full_means_active, clk_i, rst_ni, out_full, m_axis_tdata[37])
  `ASSERT_NEXT(out_holds, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_NEXT(stop_clears, clk_i, rst_ni, stop_in, m_axis_tvalid && !m_axis_tdata[37])
endmodule

bind multi_voice_sample_mixer_core mvsm_checker u_chk (.*);
`default_nettype wire

>>> dv/tb_multi_voice_sample_mixer_core.sv
// Testbench for the multi-voice sample mixer: directed and random items checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_multi_voice_sample_mixer_core;
  import mvsm_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [15:0] sample_value;
    logic [15:0] voice_length;
    logic [15:0] gain_ch0;
    logic [15:0] gain_ch1;
  } mix_item_t;

  // Highest field first so the layout matches the result bus
  typedef struct packed {
    logic        any_active;
    logic        slots_full;
    logic [3:0]  slot;
    logic [15:0] out_ch1;
    logic [15:0] out_ch0;
  } mix_result_t;

  localparam int MaxCycles = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [79:0] s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [39:0] m_axis_tdata;

  multi_voice_sample_mixer_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Predictor state
  logic [15:0] mem_words [0:65535];
  bit          voice_on [Voices];
  logic [15:0] voice_base [Voices];
  logic [15:0] voice_frames [Voices];
  logic [15:0] voice_pos [Voices];
  logic [15:0] voice_g0 [Voices];
  logic [15:0] voice_g1 [Voices];
  bit          playing;

  mix_item_t   pending_items[$];
  mix_result_t expected_frames[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          idle_off = 1'b0;
  bit          stimulus_done = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [79:0] pack_item(mix_item_t it);
    return {it.gain_ch1, it.gain_ch0, it.voice_length, it.sample_value, it.address};
  endfunction

  function automatic logic [15:0] scale_saturate(longint acc);
    longint q;
    q = acc >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit voices_busy();
    foreach (voice_on[v]) if (voice_on[v]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic mix_result_t mix_predict(mix_item_t it);
    mix_result_t r;
    longint acc0, acc1;
    logic [15:0] fa;
    int found;
    r = '0;
    acc0 = 0;
    acc1 = 0;
    found = -1;
    if (it.mode == ModeTick) begin
      r.any_active = voices_busy();
      if (playing) begin
        for (int v = 0; v < Voices; v++) begin
          if (!voice_on[v]) continue;
          if (voice_pos[v] < voice_frames[v]) begin
            fa = voice_base[v] + 16'(voice_pos[v] * 2);
            acc0 += longint'($signed(mem_words[fa])) * longint'(voice_g0[v]);
            acc1 += longint'($signed(mem_words[16'(fa + 1)])) * longint'(voice_g1[v]);
          end
          voice_pos[v] = voice_pos[v] + 16'd1;
          if (voice_pos[v] >= voice_frames[v]) voice_on[v] = 1'b0;
        end
        r.out_ch0 = scale_saturate(acc0);
        r.out_ch1 = scale_saturate(acc1);
      end
    end else if (it.mode <= ModeStop) begin
      case (it.mode)
        ModeWrite: mem_words[it.address] = it.sample_value;
        ModeStart: begin
          for (int v = 0; v < Voices && found < 0; v++) if (!voice_on[v]) found = v;
          if (found >= 0) begin
            voice_on[found] = 1'b1;
            voice_base[found] = it.address;
            voice_frames[found] = it.voice_length;
            voice_pos[found] = '0;
            voice_g0[found] = it.gain_ch0;
            voice_g1[found] = it.gain_ch1;
            r.slot = 4'(found);
          end else begin
            r.slots_full = 1'b1;
          end
          playing = 1'b1;
        end
        ModePause: playing = 1'b0;
        default: begin
          playing = 1'b0;
          foreach (voice_on[v]) voice_on[v] = 1'b0;
        end
      endcase
      r.any_active = voices_busy();
    end else begin
      r.any_active = voices_busy();
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0d] %s: got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Queue one item
  task automatic push_item(mix_item_t it);
    pending_items.push_back(it);
  endtask

  function automatic mix_item_t blank_item(logic [2:0] m);
    mix_item_t it;
    it = '0;
    it.mode = m;
    it.address = 16'($urandom);
    it.sample_value = 16'($urandom);
    it.voice_length = 16'($urandom);
    it.gain_ch0 = 16'($urandom);
    it.gain_ch1 = 16'($urandom);
    return it;
  endfunction

  task automatic write_word(logic [15:0] a, logic [15:0] d);
    mix_item_t it;
    it = blank_item(ModeWrite);
    it.address = a;
    it.sample_value = d;
    push_item(it);
  endtask

  // Optionally fill a region then start a voice over it; a filled region covers every frame read
  task automatic start_voice(logic [15:0] base, logic [15:0] frames,
                             logic [15:0] g0, logic [15:0] g1, bit fill);
    mix_item_t it;
    if (fill)
      for (int i = 0; i < 2 * frames; i++) write_word(16'(base + i), 16'($urandom));
    it = blank_item(ModeStart);
    it.address = base;
    it.voice_length = frames;
    it.gain_ch0 = g0;
    it.gain_ch1 = g1;
    push_item(it);
  endtask

  // Stimulus
  initial begin
    int n, f;
    logic [15:0] base;
    // Directed: extreme samples at wrap boundary, saturation, full slots, zero length
    write_word(16'hFFFF, 16'h7FFF);
    write_word(16'h0000, 16'h8000);
    write_word(16'hFFFE, 16'h8000);
    push_item(blank_item(ModeTick));          // tick while idle
    start_voice(16'hFFFE, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    start_voice(16'hFFFE, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    start_voice(16'hFFFF, 16'd1, 16'h8000, 16'h0000, 1'b0);
    start_voice(16'h1234, 16'd0, 16'h8000, 16'h8000, 1'b0);  // zero length
    push_item(blank_item(ModePause));
    push_item(blank_item(ModeTick));          // tick while paused
    start_voice(16'hFFFF, 16'd1, 16'h0000, 16'hFFFF, 1'b0);
    push_item(blank_item(ModeTick));          // saturating mix, wrapped reads
    for (int i = 0; i < 17; i++) start_voice(16'hFFFE, 16'd1, 16'd1, 16'd1, 1'b0);
    push_item(blank_item(ModeStop));
    push_item(blank_item(3'd5));
    push_item(blank_item(3'd7));
    push_item(blank_item(ModeTick));

    // Random: mostly well-formed voice sequences with ticks, some noise
    while (pending_items.size() < 1600) begin
      n = $urandom_range(0, 99);
      if (n < 30) begin
        f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        base = 16'($urandom);
        start_voice(base, 16'(f),
                    ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom), 1'b1);
      end else if (n < 80) begin
        push_item(blank_item(ModeTick));
      end else if (n < 85) begin
        push_item(blank_item(ModePause));
      end else if (n < 88) begin
        push_item(blank_item(ModeStop));
      end else if (n < 93) begin
        push_item(blank_item(3'($urandom_range(5, 7))));
      end else begin
        write_word(16'($urandom), 16'($urandom));
      end
    end
    // One final start of the longest legal length, full gains
    start_voice(16'($urandom), 16'd32768, 16'hFFFF, 16'hFFFF, 1'b0);
    push_item(blank_item(ModeStop));
  end

  // Long-length start needs memory over its whole range: zero the predictor memory once up front
  initial begin
    for (int a = 0; a < 65536; a++) mem_words[a] = '0;
  end

  // Reset, end of run
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver
  int send_gap = 0;
  int sent = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_frames.push_back(mix_predict(pending_items.pop_front()));
        sent <= sent + 1;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (pending_items.size() > 0) begin
        if (!idle_off && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 11) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_items[0].mode;
          s_axis_tdata <= pack_item(pending_items[0]);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      if (pending_items.size() < 150) idle_off <= 1'b1;
    end
  end

  // Monitor and receiver stall
  int recv_gap = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk_i) begin
    mix_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[37:0];
        if (expected_frames.size() == 0) begin
          $display("[%0d] result with nothing expected", cycle_count);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (got.out_ch0 !== want.out_ch0) report_mismatch("out_ch0", got.out_ch0, want.out_ch0);
          if (got.out_ch1 !== want.out_ch1) report_mismatch("out_ch1", got.out_ch1, want.out_ch1);
          if (got.slot !== want.slot) report_mismatch("slot", 16'(got.slot), 16'(want.slot));
          if (got.slots_full !== want.slots_full)
            report_mismatch("slots_full", 16'(got.slots_full), 16'(want.slots_full));
          if (got.any_active !== want.any_active)
            report_mismatch("any_active", 16'(got.any_active), 16'(want.any_active));
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (!long_hold_done && sent == 400) begin
        long_hold_done <= 1'b1;
        recv_gap <= 300;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (idle_off && pending_items.size() == 0 && !s_axis_tvalid &&
          expected_frames.size() == 0)
        stimulus_done <= 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+src
src/mvsm_pkg.sv
src/mvsm_datapath.sv
src/mvsm_ctrl.sv
src/multi_voice_sample_mixer_core.sv
src/mvsm_checker.sv
dv/tb_multi_voice_sample_mixer_core.sv
